### hw/rtl/gld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;

    localparam int TableEntries = 4096;
    localparam int MaxCodeBits  = 12;
    localparam int IdxW         = 12;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_END   = 2'd2,
        CMD_PULL  = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NEED    = 3'd1;
    localparam logic [2:0] ST_CORRUPT = 3'd2;
    localparam logic [2:0] ST_PAD     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_OUT,
        S_CODE,
        S_WALK_RD,
        S_WALK,
        S_FINISH,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;      // start image
        logic push;       // push byte
        logic set_end;    // mark end of data
        logic pop_rd;     // read stack top
        logic code_eval;  // take and classify a code
        logic walk_rd;    // read table at walk code
        logic walk_step;  // push suffix, follow prefix
        logic finish;     // add entry, set result
        logic fresh_eval; // clear fresh before code
    } t_cmd_s;

    // datapath to controller
    typedef struct packed {
        logic stream_done;
        logic fresh;
        logic stack_nz;
        logic code_done;  // code handled, result ready
        logic code_clear; // clear code taken, read another code
        logic walk_more;  // walk code still a string
    } t_stat_s;

endpackage
`default_nettype wire

### hw/rtl/gld_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gld_datapath
    import gld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [3:0] i_min_code_size,
    input  wire logic [7:0] i_data_byte,
    input  wire t_cmd_s     i_cmd,
    output t_stat_s         o_stat,
    output logic [7:0]      o_pixel,
    output logic            o_pixel_valid,
    output logic [2:0]      o_status
);

    // tables and stack
    logic [IdxW-1:0] r_prefix [TableEntries];
    logic [7:0]      r_suffix [TableEntries];
    logic [7:0]      r_stack  [TableEntries];
    logic [IdxW-1:0] r_pre_q;
    logic [7:0]      r_suf_q;
    logic [7:0]      r_stk_q;

    logic [3:0]  r_size;
    logic [12:0] r_depth;
    logic [31:0] r_buf;
    logic [5:0]  r_cnt;
    logic [3:0]  r_width;
    logic [12:0] r_nfc, r_limit;
    logic [7:0]  r_first;
    logic [IdxW-1:0] r_prev, r_incode, r_walk;
    logic r_fresh, r_inclr, r_ended, r_done;
    logic [7:0] r_pix;
    logic r_pv;
    logic [2:0] r_st, r_wst;

    logic [12:0] clr;
    logic [3:0]  sz_lat;
    logic        have;
    logic [11:0] code;
    logic [12:0] code13;

    assign clr    = 13'd1 << r_size;
    assign sz_lat = (i_min_code_size < 4'd2) ? 4'd2 :
                    ((i_min_code_size > 4'd11) ? 4'd11 : i_min_code_size);
    assign have   = r_cnt >= {2'b00, r_width};
    assign code   = r_buf[11:0] & ((12'd1 << r_width) - 12'd1);
    assign code13 = {1'b0, code};

    // table and stack memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_rd) begin
            r_pre_q <= r_prefix[r_walk];
            r_suf_q <= r_suffix[r_walk];
        end
        if (i_cmd.pop_rd) r_stk_q <= r_stack[r_depth[11:0] - 12'd1];
        if (i_cmd.finish && r_nfc < 13'(TableEntries)) begin
            r_prefix[r_nfc[11:0]] <= r_prev;
            r_suffix[r_nfc[11:0]] <= (r_walk >= clr[11:0] && clr < 13'd4096) ?
                                     r_first : r_walk[7:0];
        end
        if (i_cmd.walk_step && r_depth < 13'(TableEntries))
            r_stack[r_depth[11:0]] <= r_suf_q;
        else if (i_cmd.code_eval && r_depth < 13'(TableEntries) && have && !r_inclr
                 && code13 != clr && code13 != clr + 13'd1 && code13 >= r_nfc)
            r_stack[r_depth[11:0]] <= r_first;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_size  <= i_rst_n ? sz_lat : 4'd8;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_ended <= 1'b0;
            r_done  <= 1'b0;
            r_fresh <= 1'b1;
            r_inclr <= 1'b0;
            r_first <= '0;
            r_prev  <= '0;
            r_depth <= '0;
            r_width <= (i_rst_n ? sz_lat : 4'd8) + 4'd1;
            r_nfc   <= (13'd1 << (i_rst_n ? sz_lat : 4'd8)) + 13'd2;
            r_limit <= 13'd2 << (i_rst_n ? sz_lat : 4'd8);
            r_pix   <= '0;
            r_pv    <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            if (i_cmd.push) begin
                r_pix <= '0;
                r_pv  <= 1'b0;
                if (r_cnt > 6'd24) r_st <= ST_FULL;
                else begin
                    r_buf <= r_buf | ({24'd0, i_data_byte} << r_cnt);
                    r_cnt <= r_cnt + 6'd8;
                    r_st  <= ST_OK;
                end
            end
            if (i_cmd.set_end) begin
                r_ended <= 1'b1;
                r_pix <= '0; r_pv <= 1'b0; r_st <= ST_OK;
            end
            if (i_cmd.fresh_eval) begin
                r_fresh <= 1'b0;
                r_inclr <= 1'b1;
                r_width <= r_size + 4'd1;
                r_limit <= clr << 1;
                r_nfc   <= clr + 13'd2;
                r_depth <= '0;
            end
            if (i_cmd.pop_rd) r_depth <= r_depth - 13'd1;
            if (i_cmd.code_eval) begin
                if (r_done) begin
                    r_pix <= '0; r_pv <= 1'b1; r_st <= ST_PAD;
                end else if (!have && !r_ended) begin
                    r_pix <= '0; r_pv <= 1'b0; r_st <= ST_NEED;
                end else if (r_inclr) begin
                    if (have) begin
                        r_buf <= r_buf >> r_width;
                        r_cnt <= r_cnt - {2'b00, r_width};
                    end
                    if (have && code13 == clr) begin
                        r_width <= r_size + 4'd1;
                        r_limit <= clr << 1;
                        r_nfc   <= clr + 13'd2;
                        r_depth <= '0;
                    end else begin
                        r_inclr <= 1'b0;
                        r_pv    <= 1'b1;
                        if (!have || code13 > clr) begin
                            r_first <= '0; r_prev <= '0; r_pix <= '0; r_st <= ST_CORRUPT;
                        end else begin
                            r_first <= code[7:0]; r_prev <= code;
                            r_pix <= code[7:0]; r_st <= ST_OK;
                        end
                    end
                end else if (!have) begin
                    r_done <= 1'b1;
                    r_pix <= '0; r_pv <= 1'b1; r_st <= ST_PAD;
                end else begin
                    r_buf <= r_buf >> r_width;
                    r_cnt <= r_cnt - {2'b00, r_width};
                    if (code13 == clr) begin
                        r_width <= r_size + 4'd1;
                        r_limit <= clr << 1;
                        r_nfc   <= clr + 13'd2;
                        r_depth <= '0;
                        r_inclr <= 1'b1;
                    end else if (code13 == clr + 13'd1) begin
                        r_done <= 1'b1;
                        r_pix <= '0; r_pv <= 1'b1; r_st <= ST_PAD;
                    end else begin
                        r_incode <= code;
                        r_wst    <= ST_OK;
                        r_walk   <= code;
                        if (code13 >= r_nfc) begin
                            if (code13 > r_nfc) begin
                                r_wst <= ST_CORRUPT; r_incode <= '0;
                            end
                            if (r_depth < 13'(TableEntries)) r_depth <= r_depth + 13'd1;
                            r_walk <= r_prev;
                        end
                    end
                end
            end
            if (i_cmd.walk_step) begin
                if (r_depth < 13'(TableEntries)) r_depth <= r_depth + 13'd1;
                r_walk <= r_pre_q;
            end
            if (i_cmd.finish) begin
                r_first <= r_walk[7:0];
                r_pix   <= r_walk[7:0];
                r_pv    <= 1'b1;
                r_st    <= r_wst;
                r_prev  <= r_incode;
                if (r_nfc < 13'(TableEntries)) begin
                    r_nfc <= r_nfc + 13'd1;
                    if (r_nfc + 13'd1 >= r_limit && r_width < 4'(MaxCodeBits)) begin
                        r_width <= r_width + 4'd1;
                        r_limit <= r_limit << 1;
                    end
                end
            end
        end
    end

    // pop result shows the read stack byte until the next item changes the result
    logic r_popped;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_popped <= 1'b0;
        else if (i_cmd.pop_rd) r_popped <= 1'b1;
        else if (i_cmd.start || i_cmd.push || i_cmd.set_end || i_cmd.fresh_eval ||
                 i_cmd.code_eval || i_cmd.finish)
            r_popped <= 1'b0;
    end

    assign o_pixel       = r_popped ? r_stk_q : r_pix;
    assign o_pixel_valid = r_popped ? 1'b1 : r_pv;
    assign o_status      = r_popped ? ST_OK : r_st;

    // status to controller
    always_comb begin
        o_stat.stream_done = r_done;
        o_stat.fresh       = r_fresh;
        o_stat.stack_nz    = r_depth != 13'd0;
        o_stat.code_done   = r_done || (!have && !r_ended) ||
                             (r_inclr && !(have && code13 == clr)) ||
                             (!r_inclr && (!have || code13 == clr + 13'd1));
        o_stat.code_clear  = !r_done && have && code13 == clr;
        o_stat.walk_more   = ({1'b0, r_walk} >= clr);
    end

    // a pushed byte always lands below the buffer top
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 6'd32)
        else $error("bit count overflow");
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= 13'(TableEntries)) else $error("stack depth overflow");
    a_width_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width <= 4'(MaxCodeBits)) else $error("code width overflow");

endmodule
`default_nettype wire

### hw/rtl/gld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gld_ctrl
    import gld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_command,
    input  wire logic       i_out_stall,
    input  wire t_stat_s    i_stat,
    output t_cmd_s          o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    t_state r_state, n_state;
    logic   r_ov;
    logic   take, done;

    assign o_in_stall  = (r_state != S_IDLE) || (r_ov && i_out_stall);
    assign take        = i_valid && !o_in_stall;
    assign o_out_valid = r_ov;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take && t_cmd'(i_command) == CMD_PULL) begin
                if (!i_stat.stream_done && !i_stat.fresh && i_stat.stack_nz)
                    n_state = S_POP_RD;
                else n_state = S_CODE;
            end
            S_POP_RD:  n_state = S_IDLE;
            S_POP_OUT: n_state = S_IDLE;
            S_CODE:    if (!i_stat.fresh) begin
                if (i_stat.code_done) n_state = S_IDLE;
                else if (!i_stat.code_clear) n_state = S_WALK;
            end
            S_WALK:    n_state = i_stat.walk_more ? S_WALK_RD : S_FINISH;
            S_WALK_RD: n_state = S_OUT;
            S_OUT:     n_state = S_WALK;
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        done  = 1'b0;
        unique case (r_state)
            S_IDLE: if (take) begin
                o_cmd.start   = t_cmd'(i_command) == CMD_START;
                o_cmd.push    = t_cmd'(i_command) == CMD_PUSH;
                o_cmd.set_end = t_cmd'(i_command) == CMD_END;
                o_cmd.pop_rd  = t_cmd'(i_command) == CMD_PULL && !i_stat.stream_done &&
                                !i_stat.fresh && i_stat.stack_nz;
                done = t_cmd'(i_command) != CMD_PULL;
            end
            S_POP_RD: done = 1'b1;
            S_CODE: begin
                o_cmd.fresh_eval = i_stat.fresh && !i_stat.stream_done;
                o_cmd.code_eval  = !(i_stat.fresh && !i_stat.stream_done);
                done = !(i_stat.fresh && !i_stat.stream_done) && i_stat.code_done;
            end
            S_WALK: begin
                o_cmd.walk_rd = i_stat.walk_more;
                o_cmd.finish  = !i_stat.walk_more;
                done = !i_stat.walk_more;
            end
            S_OUT: o_cmd.walk_step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && !(r_state == S_IDLE && t_cmd'(i_command) == CMD_PULL)) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall) r_ov <= 1'b0;
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !take) else $error("item taken while busy");
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> r_ov) else $error("result dropped");
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_RD) |=> (r_state == S_OUT)) else $error("walk order");

endmodule
`default_nettype wire

### hw/rtl/gif_lzw_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Push, start and end finish in the idle state. A pull pops the stack when it
// holds pixels, else reads a code, with an extra step for a fresh image, one per
// clear code and one when an entry is added, plus a read and a push per table entry walked (one table read port).
// Items are taken one at a time; the input stalls while an item is in progress.
// Reset: synchronous active low; clears control state and sets min code size 8.
module gif_lzw_decoder_unit
    import gld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_pixel,
    output logic            o_pixel_valid,
    output logic [2:0]      o_status
);

    t_cmd_s  cmd;
    t_stat_s stat;
    logic [3:0] r_cfg;

    // hold register value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= 4'd8;
        else if (i_cfg_we) r_cfg <= i_cfg_wdata;
    end

    gld_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_command,
        .i_out_stall(i_stall), .i_stat(stat), .o_cmd(cmd),
        .o_in_stall(o_stall), .o_out_valid(o_valid)
    );

    gld_datapath u_dp (
        .i_clk, .i_rst_n, .i_min_code_size(r_cfg), .i_data_byte,
        .i_cmd(cmd), .o_stat(stat), .o_pixel, .o_pixel_valid, .o_status
    );

endmodule
`default_nettype wire
